>>> sv/ipv4hv_pkg.sv
// Shared types, constants and helpers for the IPv4 header validator.
`timescale 1ns / 1ps

package ipv4hv_pkg;

   localparam int CountWidth = 17;
   typedef logic [CountWidth-1:0] count_type;
   localparam count_type CountMax = '1;

   localparam logic [3:0] VersionNibble  = 4'h4;
   localparam count_type  MinHeaderBytes = count_type'(20);
   localparam int         EvilBit        = 15;
   localparam int         MfBit          = 13;
   localparam int         OffsetWidth    = 13;

   typedef enum logic [3:0] {
      ERR_NONE,
      ERR_SHORT,
      ERR_VERSION,
      ERR_IHL_SMALL,
      ERR_IHL_LONG,
      ERR_LENGTH,
      ERR_EVIL,
      ERR_FRAGMENT,
      ERR_CHECKSUM
   } error_type;

   // Packet fields as they stand after the current byte has been taken in.
   typedef struct packed {
      count_type   count;
      logic [7:0]  version_ihl;
      logic [15:0] total_length;
      logic [15:0] flags_fragment;
      logic [15:0] checksum;
   } fields_type;

   // Ones'-complement add with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

endpackage

>>> sv/ipv4hv_req_if.sv
// Byte channel into the validator: valid/ready with packet byte and end flag.
`timescale 1ns / 1ps

interface ipv4hv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/ipv4hv_rsp_if.sv
// Verdict channel out of the validator: valid/ready with good flag and error code.
`timescale 1ns / 1ps

interface ipv4hv_rsp_if;
   logic       valid;
   logic       ready;
   logic       packet_good;
   logic [3:0] error_code;

   modport source (output valid, output packet_good, output error_code, input ready);
   modport sink   (input valid, input packet_good, input error_code, output ready);
endinterface

>>> sv/ipv4hv_acc.sv
// Per-packet state: byte count, captured header fields and running header checksum.
`timescale 1ns / 1ps

module ipv4hv_acc (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_valid,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   output ipv4hv_pkg::fields_type fields
);

   ipv4hv_pkg::count_type count_ff, count_in;
   logic [7:0]  vihl_ff, vihl_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] flags_ff, flags_in;
   logic [15:0] csum_ff, csum_in;
   logic [7:0]  pend_ff, pend_in;
   logic [5:0]  hdr_bytes;
   logic        in_header;

   always_comb begin
      vihl_in  = (count_ff == ipv4hv_pkg::count_type'(0)) ? data_byte : vihl_ff;
      len_in   = len_ff;
      flags_in = flags_ff;
      if (count_ff == ipv4hv_pkg::count_type'(2)) len_in[15:8] = data_byte;
      if (count_ff == ipv4hv_pkg::count_type'(3)) len_in[7:0] = data_byte;
      if (count_ff == ipv4hv_pkg::count_type'(6)) flags_in[15:8] = data_byte;
      if (count_ff == ipv4hv_pkg::count_type'(7)) flags_in[7:0] = data_byte;

      hdr_bytes = {vihl_in[3:0], 2'b00};
      in_header = count_ff < ipv4hv_pkg::count_type'(hdr_bytes);
      pend_in   = (in_header && !count_ff[0]) ? data_byte : pend_ff;
      csum_in   = (in_header && count_ff[0]) ?
                  ipv4hv_pkg::ones_add(csum_ff, {pend_ff, data_byte}) : csum_ff;

      count_in = (count_ff == ipv4hv_pkg::CountMax) ? count_ff : count_ff + 1'b1;

      fields.count          = count_in;
      fields.version_ihl    = vihl_in;
      fields.total_length   = len_in;
      fields.flags_fragment = flags_in;
      fields.checksum       = csum_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step_valid && last_byte)) begin
         count_ff <= '0;
         vihl_ff  <= '0;
         len_ff   <= '0;
         flags_ff <= '0;
         csum_ff  <= '0;
         pend_ff  <= '0;
      end else if (step_valid) begin
         count_ff <= count_in;
         vihl_ff  <= vihl_in;
         len_ff   <= len_in;
         flags_ff <= flags_in;
         csum_ff  <= csum_in;
         pend_ff  <= pend_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      step_valid && last_byte |=> count_ff == '0 && csum_ff == '0)
      else $error("packet state not cleared after last byte");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      step_valid && !last_byte && count_ff == ipv4hv_pkg::CountMax |=>
      count_ff == ipv4hv_pkg::CountMax)
      else $error("byte count wrapped");

endmodule

>>> sv/ipv4hv_verdict.sv
// Ordered header checks and the result register that drives the verdict channel.
`timescale 1ns / 1ps

module ipv4hv_verdict (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ipv4hv_pkg::fields_type fields,
   ipv4hv_rsp_if.source           rsp_chan
);

   ipv4hv_pkg::error_type code_in, code_ff;
   logic                  valid_ff;
   logic [5:0]            hdr_bytes;
   ipv4hv_pkg::count_type hdr_count;

   always_comb begin
      hdr_bytes = {fields.version_ihl[3:0], 2'b00};
      hdr_count = ipv4hv_pkg::count_type'(hdr_bytes);
      if (fields.count < ipv4hv_pkg::MinHeaderBytes)
         code_in = ipv4hv_pkg::ERR_SHORT;
      else if (fields.version_ihl[7:4] != ipv4hv_pkg::VersionNibble)
         code_in = ipv4hv_pkg::ERR_VERSION;
      else if (hdr_count < ipv4hv_pkg::MinHeaderBytes)
         code_in = ipv4hv_pkg::ERR_IHL_SMALL;
      else if (hdr_count > fields.count)
         code_in = ipv4hv_pkg::ERR_IHL_LONG;
      else if (ipv4hv_pkg::count_type'(fields.total_length) != fields.count)
         code_in = ipv4hv_pkg::ERR_LENGTH;
      else if (fields.flags_fragment[ipv4hv_pkg::EvilBit])
         code_in = ipv4hv_pkg::ERR_EVIL;
      else if (fields.flags_fragment[ipv4hv_pkg::MfBit] ||
               (fields.flags_fragment[ipv4hv_pkg::OffsetWidth-1:0] != '0))
         code_in = ipv4hv_pkg::ERR_FRAGMENT;
      else if (fields.checksum != 16'hFFFF)
         code_in = ipv4hv_pkg::ERR_CHECKSUM;
      else
         code_in = ipv4hv_pkg::ERR_NONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
      if (load) code_ff <= code_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.error_code  = code_ff;
   assign rsp_chan.packet_good = (code_ff == ipv4hv_pkg::ERR_NONE);

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_chan.ready |-> !load)
      else $error("pending verdict overwritten");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> code_ff <= ipv4hv_pkg::ERR_CHECKSUM)
      else $error("verdict code out of range");

endmodule

>>> sv/ipv4_header_validator.sv
// Top level of the IPv4 header validator: input register, packet state, verdict.
// A byte taken into the input register is folded into the packet state when it leaves
//   that register; for a last byte that same edge loads the verdict onto rsp_chan.
// Throughput: one byte per cycle; the verdict register stalls the input register
//   only when it still holds an untaken verdict and another last byte is waiting.
// Reset (synchronous, active high) empties both registers and clears packet state.
`timescale 1ns / 1ps

module ipv4_header_validator (
   input  logic         clock,
   input  logic         reset,
   ipv4hv_req_if.sink   req_chan,
   ipv4hv_rsp_if.source rsp_chan
);

   logic                   s1_valid_ff;
   logic [7:0]             s1_byte_ff;
   logic                   s1_last_ff;
   logic                   out_hold;
   logic                   s1_advance;
   logic                   take;
   ipv4hv_pkg::fields_type fields;

   assign out_hold       = rsp_chan.valid && !rsp_chan.ready;
   assign s1_advance     = s1_valid_ff && (!s1_last_ff || !out_hold);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (take) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
      end
   end

   ipv4hv_acc u_acc (
      .clock      (clock),
      .reset      (reset),
      .step_valid (s1_advance),
      .data_byte  (s1_byte_ff),
      .last_byte  (s1_last_ff),
      .fields     (fields)
   );

   ipv4hv_verdict u_verdict (
      .clock    (clock),
      .reset    (reset),
      .load     (s1_advance && s1_last_ff),
      .fields   (fields),
      .rsp_chan (rsp_chan)
   );

   a_stalled_last_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && out_hold |=> s1_valid_ff && s1_last_ff)
      else $error("stalled last byte dropped");

   a_verdict_follows_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("verdict without last byte");

   a_good_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.packet_good == (rsp_chan.error_code == ipv4hv_pkg::ERR_NONE))
      else $error("good flag disagrees with code");

endmodule

>>> bench/tb_ipv4_header_validator.sv
// Testbench for the IPv4 header validator: directed packet table, then random packets.
`timescale 1ns / 1ps

module tb_ipv4_header_validator;

   localparam int CycleLimit = 2_000_000;

   typedef struct packed {
      logic                  good;
      ipv4hv_pkg::error_type code;
   } verdict_type;

   typedef struct packed {
      int unsigned           nbytes;
      logic [7:0]            ver_ihl;
      int                    tot_len;    // -1: use the byte count
      logic [15:0]           frag;
      logic                  good_csum;
      logic [7:0]            fill;
      logic                  typed;
      ipv4hv_pkg::error_type want;
   } packet_spec_type;

   localparam int NumRows = 20;
   localparam packet_spec_type DirectedRows [NumRows] = '{
      '{1,  8'h45, -1, 16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_SHORT},
      '{19, 8'h45, -1, 16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_SHORT},
      '{20, 8'h45, -1, 16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_NONE},
      '{20, 8'hFF, -1, 16'h0000, 1'b1, 8'hFF, 1'b1, ipv4hv_pkg::ERR_VERSION},
      '{20, 8'h05, -1, 16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_VERSION},
      '{20, 8'h44, -1, 16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_IHL_SMALL},
      '{20, 8'h40, -1, 16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_IHL_SMALL},
      '{24, 8'h46, -1, 16'h0000, 1'b1, 8'hFF, 1'b0, ipv4hv_pkg::ERR_NONE},
      '{40, 8'h4F, -1, 16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_IHL_LONG},
      '{60, 8'h4F, -1, 16'h0000, 1'b1, 8'hFF, 1'b1, ipv4hv_pkg::ERR_NONE},
      '{30, 8'h45, 31, 16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_LENGTH},
      '{20, 8'h45, 0,  16'h0000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_LENGTH},
      '{20, 8'h45, -1, 16'h8000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_EVIL},
      '{20, 8'h45, -1, 16'hFFFF, 1'b1, 8'hFF, 1'b1, ipv4hv_pkg::ERR_EVIL},
      '{20, 8'h45, -1, 16'h2000, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_FRAGMENT},
      '{20, 8'h45, -1, 16'h0001, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_FRAGMENT},
      '{20, 8'h45, -1, 16'h1FFF, 1'b1, 8'h00, 1'b1, ipv4hv_pkg::ERR_FRAGMENT},
      '{20, 8'h45, -1, 16'h4000, 1'b1, 8'hFF, 1'b1, ipv4hv_pkg::ERR_NONE},
      '{20, 8'h45, -1, 16'h0000, 1'b0, 8'h00, 1'b1, ipv4hv_pkg::ERR_CHECKSUM},
      '{64, 8'h47, -1, 16'h0000, 1'b0, 8'hA5, 1'b0, ipv4hv_pkg::ERR_NONE}
   };

   logic clock = 1'b0;
   logic reset;

   ipv4hv_req_if req_if ();
   ipv4hv_rsp_if rsp_if ();

   ipv4_header_validator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   verdict_type verdict_q [$];
   logic [7:0]  pkt_bytes [$];
   int          mismatches = 0;
   logic        idle_on = 1'b1;
   int          hold_left = 0;

   // predictor state
   ipv4hv_pkg::count_type seen_count;
   logic [7:0]            hdr_ver_ihl;
   logic [15:0]           hdr_total_len;
   logic [15:0]           hdr_frag;
   logic [15:0]           hdr_sum;
   logic [7:0]            hi_byte;

   function automatic logic [15:0] wrap_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

   task automatic clear_packet_state();
      seen_count    = '0;
      hdr_ver_ihl   = '0;
      hdr_total_len = '0;
      hdr_frag      = '0;
      hdr_sum       = '0;
      hi_byte       = '0;
   endtask

   task automatic absorb_byte(input logic [7:0] b, input logic l,
                              output logic done, output verdict_type v);
      ipv4hv_pkg::count_type idx;
      ipv4hv_pkg::count_type hl;
      ipv4hv_pkg::count_type cnt;
      ipv4hv_pkg::error_type code;
      idx = seen_count;
      case (idx)
         ipv4hv_pkg::count_type'(0): hdr_ver_ihl = b;
         ipv4hv_pkg::count_type'(2): hdr_total_len[15:8] = b;
         ipv4hv_pkg::count_type'(3): hdr_total_len[7:0] = b;
         ipv4hv_pkg::count_type'(6): hdr_frag[15:8] = b;
         ipv4hv_pkg::count_type'(7): hdr_frag[7:0] = b;
         default: ;
      endcase
      hl = ipv4hv_pkg::count_type'({hdr_ver_ihl[3:0], 2'b00});
      if (idx < hl) begin
         if (!idx[0]) hi_byte = b;
         else hdr_sum = wrap_add16(hdr_sum, {hi_byte, b});
      end
      cnt = (idx < ipv4hv_pkg::CountMax) ? idx + 1'b1 : ipv4hv_pkg::CountMax;
      done = l;
      v = '0;
      if (!l) begin
         seen_count = cnt;
      end else begin
         if (cnt < ipv4hv_pkg::MinHeaderBytes)
            code = ipv4hv_pkg::ERR_SHORT;
         else if (hdr_ver_ihl[7:4] != ipv4hv_pkg::VersionNibble)
            code = ipv4hv_pkg::ERR_VERSION;
         else if (hl < ipv4hv_pkg::MinHeaderBytes)
            code = ipv4hv_pkg::ERR_IHL_SMALL;
         else if (hl > cnt)
            code = ipv4hv_pkg::ERR_IHL_LONG;
         else if (ipv4hv_pkg::count_type'(hdr_total_len) != cnt)
            code = ipv4hv_pkg::ERR_LENGTH;
         else if (hdr_frag[ipv4hv_pkg::EvilBit])
            code = ipv4hv_pkg::ERR_EVIL;
         else if (hdr_frag[ipv4hv_pkg::MfBit] ||
                  (hdr_frag[ipv4hv_pkg::OffsetWidth-1:0] != '0))
            code = ipv4hv_pkg::ERR_FRAGMENT;
         else if (hdr_sum != 16'hFFFF)
            code = ipv4hv_pkg::ERR_CHECKSUM;
         else
            code = ipv4hv_pkg::ERR_NONE;
         v.good = (code == ipv4hv_pkg::ERR_NONE);
         v.code = code;
         clear_packet_state();
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic build_packet(input packet_spec_type s, input logic rand_fill);
      int unsigned i;
      int unsigned hl;
      logic [15:0] tl;
      logic [15:0] acc;
      logic [7:0]  b;
      pkt_bytes.delete();
      tl = (s.tot_len < 0) ? s.nbytes[15:0] : s.tot_len[15:0];
      for (i = 0; i < s.nbytes; i++) begin
         case (i)
            0: b = s.ver_ihl;
            2: b = tl[15:8];
            3: b = tl[7:0];
            6: b = s.frag[15:8];
            7: b = s.frag[7:0];
            10, 11: b = 8'h00;
            default: b = rand_fill ? 8'($urandom) : s.fill;
         endcase
         pkt_bytes.push_back(b);
      end
      hl = 32'({s.ver_ihl[3:0], 2'b00});
      if (hl > s.nbytes) hl = s.nbytes;
      acc = '0;
      for (i = 0; i + 1 < hl; i += 2) acc = wrap_add16(acc, {pkt_bytes[i], pkt_bytes[i+1]});
      if (s.nbytes >= 12) begin
         pkt_bytes[10] = ~acc[15:8];
         pkt_bytes[11] = ~acc[7:0] ^ {7'b0, !s.good_csum};
      end
   endtask

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic push_byte(input logic [7:0] b, input logic l);
      logic took;
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= l;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_if.ready;
         @(posedge clock);
      end
   endtask

   task automatic send_packet(input logic typed, input ipv4hv_pkg::error_type want);
      int unsigned i;
      logic        done;
      verdict_type v;
      for (i = 0; i < pkt_bytes.size(); i++) begin
         push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
         absorb_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, done, v);
         if (done) begin
            if (typed) verdict_q.push_back('{good: (want == ipv4hv_pkg::ERR_NONE), code: want});
            else verdict_q.push_back(v);
         end
      end
   endtask

   task automatic drain_verdicts();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
   endtask

   task automatic random_packet();
      packet_spec_type s;
      int          kind;
      int unsigned ihl;
      int unsigned n;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         pkt_bytes.delete();
         n = $urandom_range(1, 40);
         repeat (n) pkt_bytes.push_back(8'($urandom));
      end else begin
         ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
         s.ver_ihl   = {4'h4, 4'(ihl)};
         s.nbytes    = ihl * 4 + $urandom_range(0, 24);
         s.tot_len   = -1;
         s.frag      = {1'b0, 1'($urandom_range(0, 1)), 14'b0};
         s.good_csum = 1'b1;
         s.fill      = 8'h00;
         s.typed     = 1'b0;
         s.want      = ipv4hv_pkg::ERR_NONE;
         if (kind >= 65) begin
            case ($urandom_range(0, 7))
               0: s.ver_ihl[7:4] = s.ver_ihl[7:4] ^ 4'($urandom_range(1, 15));
               1: s.ver_ihl[3:0] = 4'($urandom_range(0, 4));
               2: s.tot_len = $urandom_range(0, 65535);
               3: s.frag = 16'($urandom) | 16'h8000;
               4: s.frag[ipv4hv_pkg::MfBit] = 1'b1;
               5: s.frag[ipv4hv_pkg::OffsetWidth-1:0] = 13'($urandom_range(1, 8191));
               6: s.good_csum = 1'b0;
               default: s.nbytes = $urandom_range(1, ihl * 4 - 1);
            endcase
         end
         build_packet(s, 1'b1);
      end
      send_packet(1'b0, ipv4hv_pkg::ERR_NONE);
   endtask

   always @(negedge clock) begin
      verdict_type exp_v;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("verdict good=%0d code=%0d with none expected",
                                      rsp_if.packet_good, rsp_if.error_code));
         end else begin
            exp_v = verdict_q.pop_front();
            if (rsp_if.packet_good !== exp_v.good)
               report_mismatch($sformatf("packet_good %0d, expected %0d",
                                         rsp_if.packet_good, exp_v.good));
            if (rsp_if.error_code !== exp_v.code)
               report_mismatch($sformatf("error_code %0d, expected %0d (%s)",
                                         rsp_if.error_code, exp_v.code, exp_v.code.name()));
         end
      end
   end

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && hold_left == 0 && $urandom_range(0, 5) == 0)
            hold_left = $urandom_range(1, 12);
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int unsigned bytes_sent;
      int          r;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= 8'h00;
      req_if.last_byte <= 1'b0;
      reset            <= 1'b1;
      clear_packet_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < NumRows; r++) begin
         idle_on = (DirectedRows[r].nbytes <= 1000);
         build_packet(DirectedRows[r], 1'b0);
         send_packet(DirectedRows[r].typed, DirectedRows[r].want);
      end
      idle_on = 1'b1;
      drain_verdicts();

      bytes_sent = 0;
      while (bytes_sent < 300) begin
         random_packet();
         bytes_sent += pkt_bytes.size();
         if ($urandom_range(0, 19) == 0) drain_verdicts();
      end
      // tail with no idling on either side
      idle_on = 1'b0;
      repeat (8) random_packet();

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
